@@ src/vtrd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtrd_pkg
// Shared types and constants for the radix digit converter.
// ----------------------------------------------------------------------------
package vtrd_pkg;

    localparam int DEFAULT_VALUE_BITS = 63;
    localparam int RADIX_W            = 5;
    localparam int DIGIT_W            = 4;
    localparam int M_TDATA_W          = ((DIGIT_W + 7) / 8) * 8;
    // quotient bits resolved per cycle by the divider
    localparam int DIV_STEP_BITS      = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PLAY_RD,
        ST_PLAY_LD,
        ST_PLAY_WAIT
    } state_t;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

@@ src/vtrd_div.sv @@
// ----------------------------------------------------------------------------
// vtrd_div
// Iterative divider of a wide value by a small radix, several quotient bits
// per cycle by restoring division. Remainder and quotient are ready with done.
// ----------------------------------------------------------------------------
module vtrd_div #(
    parameter int VALUE_BITS = vtrd_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start_i,
    input  logic [VALUE_BITS-1:0]           dividend_i,
    input  logic [vtrd_pkg::RADIX_W-1:0]    radix_i,
    output logic                            done_o,
    output logic [VALUE_BITS-1:0]           quot_o,
    output logic [vtrd_pkg::DIGIT_W-1:0]    rem_o
);

    localparam int STEPS    = (VALUE_BITS + vtrd_pkg::DIV_STEP_BITS - 1)
                              / vtrd_pkg::DIV_STEP_BITS;
    localparam int PAD_BITS = STEPS * vtrd_pkg::DIV_STEP_BITS;
    localparam int CNT_W    = $clog2(STEPS + 1);

    logic [PAD_BITS-1:0]                    work_reg, work_next;
    logic [vtrd_pkg::DIGIT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]                       cnt_reg;
    logic                                   done_reg;

    logic [vtrd_pkg::DIV_STEP_BITS-1:0]     chunk;
    logic [vtrd_pkg::DIV_STEP_BITS-1:0]     q_bits;
    logic [vtrd_pkg::RADIX_W-1:0]           trial;

    // one restoring step per dividend bit, top chunk first
    always_comb begin
        chunk    = work_reg[PAD_BITS-1 -: vtrd_pkg::DIV_STEP_BITS];
        rem_next = rem_reg;
        q_bits   = '0;
        trial    = '0;
        for (int i = vtrd_pkg::DIV_STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem_next, chunk[i]};
            if (trial >= radix_i) begin
                trial     = trial - radix_i;
                q_bits[i] = 1'b1;
            end
            rem_next = trial[vtrd_pkg::DIGIT_W-1:0];
        end
        work_next = (work_reg << vtrd_pkg::DIV_STEP_BITS) | PAD_BITS'(q_bits);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start_i) begin
                cnt_reg <= CNT_W'(STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            work_reg <= PAD_BITS'(dividend_i);
            rem_reg  <= '0;
        end else if (cnt_reg != '0) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done_o = done_reg;
    assign quot_o = work_reg[VALUE_BITS-1:0];
    assign rem_o  = rem_reg;

endmodule

@@ src/value_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// value_to_radix_digits
// Converts a non-negative integer into its digits in a radix of 2 to 16,
// most significant digit first, one output request per digit.
// ----------------------------------------------------------------------------
// Each accepted value is divided repeatedly by the radix on one iterative
// divider that resolves 8 quotient bits per cycle. The remainders go into a
// small digit memory and are then played back in reverse: each digit is read,
// loaded into the output register and held until the sink is ready. The block
// takes no new value until the last digit is taken; a value of zero produces
// no output. s_tready is high only between items. The radix is
// clamped to 2..16 when written and must be changed only while idle.
// ----------------------------------------------------------------------------
module value_to_radix_digits #(
    parameter int VALUE_BITS = vtrd_pkg::DEFAULT_VALUE_BITS,
    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [vtrd_pkg::RADIX_W-1:0]    cfg_wr_data,    // radix

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,        // value

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vtrd_pkg::M_TDATA_W-1:0]  m_tdata,        // digit
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    vtrd_pkg::state_t                   state_reg, state_next;
    logic [vtrd_pkg::RADIX_W-1:0]       radix_reg;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [vtrd_pkg::DIGIT_W-1:0]       store_mem [VALUE_BITS];
    logic [vtrd_pkg::DIGIT_W-1:0]       rd_data_reg;
    logic [vtrd_pkg::DIGIT_W-1:0]       digit_reg;
    logic                               last_reg;

    logic [VALUE_BITS-1:0]              value_in;
    logic                               div_start;
    logic [VALUE_BITS-1:0]              div_dividend;
    logic                               div_done;
    logic [VALUE_BITS-1:0]              div_quot;
    logic [vtrd_pkg::DIGIT_W-1:0]       div_rem;
    logic                               store_we;
    logic                               load_out;

    assign value_in = s_tdata[VALUE_BITS-1:0];

    vtrd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (div_dividend),
        .radix_i    (radix_reg),
        .done_o     (div_done),
        .quot_o     (div_quot),
        .rem_o      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= vtrd_pkg::RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= vtrd_pkg::sat_radix(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vtrd_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        div_start    = 1'b0;
        div_dividend = div_quot;
        store_we     = 1'b0;
        load_out     = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            vtrd_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                div_dividend = value_in;
                if (s_tvalid) begin
                    count_next = '0;
                    if (value_in != '0) begin
                        div_start  = 1'b1;
                        state_next = vtrd_pkg::ST_DIVIDE;
                    end
                end
            end
            vtrd_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    store_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_quot == '0 || count_reg == CNT_W'(VALUE_BITS - 1)) begin
                        idx_next   = count_reg[IDX_W-1:0];
                        state_next = vtrd_pkg::ST_PLAY_RD;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            vtrd_pkg::ST_PLAY_RD: begin
                state_next = vtrd_pkg::ST_PLAY_LD;
            end
            vtrd_pkg::ST_PLAY_LD: begin
                load_out   = 1'b1;
                state_next = vtrd_pkg::ST_PLAY_WAIT;
            end
            vtrd_pkg::ST_PLAY_WAIT: begin
                if (m_tready) begin
                    if (idx_reg == '0) begin
                        state_next = vtrd_pkg::ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = vtrd_pkg::ST_PLAY_RD;
                    end
                end
            end
            default: begin
                state_next = vtrd_pkg::ST_IDLE;
            end
        endcase
    end

    // digit memory: remainders least significant first
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[count_reg[IDX_W-1:0]] <= div_rem;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            digit_reg <= rd_data_reg;
            last_reg  <= (idx_reg == '0);
        end
    end

    assign m_tvalid = (state_reg == vtrd_pkg::ST_PLAY_WAIT);
    assign m_tdata  = vtrd_pkg::M_TDATA_W'(digit_reg);
    assign m_tlast  = last_reg;

    // no new value taken while a digit request is pending
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while output pending");

    // a remainder must always be a valid digit of the radix
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vtrd_pkg::ST_DIVIDE && div_done) |-> (div_rem < radix_reg))
        else $error("remainder not below radix");

    // the final digit comes out of memory slot zero
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (idx_reg == '0))
        else $error("last flag on a non-final digit");

endmodule
